// ===== rtl/tsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsl_pkg;

   localparam int unsigned SAMPLE_BITS = 32;

   localparam int unsigned NUM_C0 = 135135;
   localparam int unsigned NUM_C1 = 17325;
   localparam int unsigned NUM_C2 = 378;
   localparam int unsigned DEN_C0 = 135135;
   localparam int unsigned DEN_C1 = 62370;
   localparam int unsigned DEN_C2 = 3150;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

endpackage

`default_nettype wire

// ===== rtl/tanh_soft_limiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a req passes the input register, the multiplier chains, divider cells and output register
// throughput: one transaction per cycle, fully pipelined through shift-add multiplier
//    cells (one multiplier bit per cell) and restoring divider cells (one quotient bit each)
// the whole pipeline moves on one enable, held only while a result waits on rsp_tready
// reset: synchronous, clears every stage valid bit; payload registers are not reset

module tanh_soft_limiter #(
   parameter int FRAC_BITS = 24,
   parameter int OUT_BITS  = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire tsl_pkg::sample_type      req_tdata,   // sample_in
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output tsl_pkg::sample_type           rsp_tdata,   // sample_out
   output logic                          rsp_tuser    // clipped
);

   import tsl_pkg::*;

   localparam int F    = FRAC_BITS;
   localparam int WM   = SAMPLE_BITS;
   localparam int WU   = 2 * WM;
   localparam int WUB  = WU - 1;
   localparam int WL1  = ((67 > 2*F + 12) ? 67 : 2*F + 12) + 1;
   localparam int WP1  = WL1 + WUB;
   localparam int WL2  = ((WP1 > 4*F + 16) ? WP1 : 4*F + 16) + 1;
   localparam int WP2  = WL2 + WUB;
   localparam int WL3  = ((WP2 > 6*F + 18) ? WP2 : 6*F + 18) + 1;
   localparam int WP3  = WL3 + WM;
   localparam int WR   = WL3 + OUT_BITS + 32;
   localparam int WQ   = OUT_BITS + 2;
   localparam logic [31:0] SAT_POS = 32'((64'(1) << (OUT_BITS - 1)) - 64'(1));
   localparam logic [31:0] SAT_NEG = ~SAT_POS;
   localparam logic [OUT_BITS:0] HALF = (OUT_BITS+1)'(1) << (OUT_BITS - 1);

   logic advance;

   // input stage
   logic            v0_ff;
   logic            neg0_ff;
   logic [WM-1:0]   mag0_ff;

   // x^2
   logic              m0_valid;
   logic [WU-1:0]     m0_p;
   logic [WM:0]       m0_side;

   logic              va_ff, nega_ff;
   logic [WM-1:0]     maga_ff;
   logic [WUB-1:0]    ua_ff;
   logic [WL1-1:0]    pa_ff, qa_ff, pa_in, qa_in;

   logic              m1_valid;
   logic [2*WP1-1:0]  m1_p;
   logic [WM+WUB:0]   m1_side;

   logic              vb_ff, negb_ff;
   logic [WM-1:0]     magb_ff;
   logic [WUB-1:0]    ub_ff;
   logic [WL2-1:0]    pb_ff, qb_ff, pb_in, qb_in;

   logic              m2_valid;
   logic [2*WP2-1:0]  m2_p;
   logic [WM:0]       m2_side;

   logic              vc_ff, negc_ff;
   logic [WM-1:0]     magc_ff;
   logic [WL3-1:0]    pc_ff, qc_ff, pc_in, qc_in;

   logic              m3_valid;
   logic [WP3-1:0]    m3_p;
   logic [WL3:0]      m3_side;

   logic              dv    [0:WQ];
   logic [WR-1:0]     drem  [0:WQ];
   logic [WL3-1:0]    ddiv  [0:WQ-1];
   logic [WQ-1:0]     dquo  [0:WQ];
   logic              dneg  [0:WQ];

   logic              rsp_tvalid_ff, rsp_tuser_ff;
   logic [31:0]       rsp_tdata_ff;
   logic [31:0]       data_in;
   logic              clip_in;
   logic [OUT_BITS:0] mant;
   logic signed [OUT_BITS-1:0] val;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_tvalid;
         va_ff <= m0_valid;
         vb_ff <= m1_valid;
         vc_ff <= m2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg0_ff <= req_tdata[WM-1];
         mag0_ff <= req_tdata[WM-1] ? (WM'(0) - req_tdata) : req_tdata;
      end
   end

   tsl_mul_chain #(.LANES(1), .WA(WM), .WB(WM), .WS(WM+1)) u_sq (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v0_ff), .in_a(mag0_ff), .in_b(mag0_ff),
      .in_side({neg0_ff, mag0_ff}),
      .out_valid(m0_valid), .out_p(m0_p), .out_side(m0_side)
   );

   always_comb begin
      pa_in = WL1'(m0_p) + (WL1'(NUM_C2) << (2*F));
      qa_in = (WL1'(m0_p) << 4) + (WL1'(m0_p) << 3) + (WL1'(m0_p) << 2)
            + (WL1'(DEN_C2) << (2*F));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff   <= pa_in;
         qa_ff   <= qa_in;
         nega_ff <= m0_side[WM];
         maga_ff <= m0_side[WM-1:0];
         ua_ff   <= m0_p[WUB-1:0];
      end
   end

   tsl_mul_chain #(.LANES(2), .WA(WL1), .WB(WUB), .WS(WM+WUB+1)) u_m1 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(va_ff), .in_a({qa_ff, pa_ff}), .in_b(ua_ff),
      .in_side({nega_ff, maga_ff, ua_ff}),
      .out_valid(m1_valid), .out_p(m1_p), .out_side(m1_side)
   );

   always_comb begin
      pb_in = WL2'(m1_p[0 +: WP1])   + (WL2'(NUM_C1) << (4*F));
      qb_in = WL2'(m1_p[WP1 +: WP1]) + (WL2'(DEN_C1) << (4*F));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pb_ff   <= pb_in;
         qb_ff   <= qb_in;
         negb_ff <= m1_side[WM+WUB];
         magb_ff <= m1_side[WUB +: WM];
         ub_ff   <= m1_side[WUB-1:0];
      end
   end

   tsl_mul_chain #(.LANES(2), .WA(WL2), .WB(WUB), .WS(WM+1)) u_m2 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(vb_ff), .in_a({qb_ff, pb_ff}), .in_b(ub_ff),
      .in_side({negb_ff, magb_ff}),
      .out_valid(m2_valid), .out_p(m2_p), .out_side(m2_side)
   );

   always_comb begin
      pc_in = WL3'(m2_p[0 +: WP2])   + (WL3'(NUM_C0) << (6*F));
      qc_in = WL3'(m2_p[WP2 +: WP2]) + (WL3'(DEN_C0) << (6*F));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pc_ff   <= pc_in;
         qc_ff   <= qc_in;
         negc_ff <= m2_side[WM];
         magc_ff <= m2_side[WM-1:0];
      end
   end

   tsl_mul_chain #(.LANES(1), .WA(WL3), .WB(WM), .WS(WL3+1)) u_m3 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(vc_ff), .in_a(pc_ff), .in_b(magc_ff),
      .in_side({negc_ff, qc_ff}),
      .out_valid(m3_valid), .out_p(m3_p), .out_side(m3_side)
   );

   assign dv[0]   = m3_valid;
   assign drem[0] = WR'(m3_p) << (OUT_BITS - 1);
   assign ddiv[0] = m3_side[WL3-1:0];
   assign dquo[0] = '0;
   assign dneg[0] = m3_side[WL3];

   // top quotient bit flags a value beyond the output range
   for (genvar j = 0; j < WQ; j++) begin : g_div
      if (j < WQ - 1) begin : g_mid
         tsl_div_cell #(
            .WR(WR), .WD(WL3), .WQ(WQ), .SH(F + WQ - 1 - j), .QBIT(WQ - 1 - j)
         ) u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .in_valid(dv[j]), .in_rem(drem[j]), .in_div(ddiv[j]),
            .in_quo(dquo[j]), .in_neg(dneg[j]),
            .out_valid(dv[j+1]), .out_rem(drem[j+1]), .out_div(ddiv[j+1]),
            .out_quo(dquo[j+1]), .out_neg(dneg[j+1])
         );
      end else begin : g_last
         tsl_div_cell #(
            .WR(WR), .WD(WL3), .WQ(WQ), .SH(F), .QBIT(0)
         ) u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .in_valid(dv[j]), .in_rem(drem[j]), .in_div(ddiv[j]),
            .in_quo(dquo[j]), .in_neg(dneg[j]),
            .out_valid(dv[j+1]), .out_rem(drem[j+1]), .out_div(),
            .out_quo(dquo[j+1]), .out_neg(dneg[j+1])
         );
      end
   end

   always_comb begin
      mant = dquo[WQ][OUT_BITS:0];
      if (dneg[WQ]) begin
         clip_in = dquo[WQ][WQ-1] || (mant > HALF);
         val     = clip_in ? $signed(OUT_BITS'(HALF))
                           : $signed(OUT_BITS'(0) - mant[OUT_BITS-1:0]);
      end else begin
         clip_in = dquo[WQ][WQ-1] || (mant >= HALF);
         val     = clip_in ? $signed(OUT_BITS'(HALF - (OUT_BITS+1)'(1)))
                           : $signed(mant[OUT_BITS-1:0]);
      end
      data_in = 32'(val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= dv[WQ];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= data_in;
         rsp_tuser_ff <= clip_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == SAT_POS || rsp_tdata == SAT_NEG))
      else $error("clipped result not at a rail");

   a_ovf_clips: assert property (@(posedge clock) disable iff (reset)
      advance && dv[WQ] && dquo[WQ][WQ-1] |=> rsp_tvalid && rsp_tuser)
      else $error("range overflow not flagged");

endmodule

`default_nettype wire

// ===== rtl/tsl_mul_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsl_mul_cell #(
   parameter int LANES = 1,
   parameter int WA = 32,
   parameter int WB = 32,
   parameter int WP = 64,
   parameter int WS = 1,
   parameter int IDX = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire logic [LANES*WA-1:0]   in_a,
   input  wire logic [WB-1:0]         in_b,
   input  wire logic [LANES*WP-1:0]   in_acc,
   input  wire logic [WS-1:0]         in_side,
   output logic                       out_valid,
   output logic [LANES*WA-1:0]        out_a,
   output logic [WB-1:0]              out_b,
   output logic [LANES*WP-1:0]        out_acc,
   output logic [WS-1:0]              out_side
);

   logic                  valid_ff;
   logic [LANES*WA-1:0]   a_ff;
   logic [WB-1:0]         b_ff;
   logic [LANES*WP-1:0]   acc_ff;
   logic [LANES*WP-1:0]   acc_in;
   logic [WS-1:0]         side_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         acc_in[l*WP +: WP] = in_acc[l*WP +: WP]
            + (in_b[IDX] ? (WP'(in_a[l*WA +: WA]) << IDX) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff    <= in_a;
         b_ff    <= in_b;
         acc_ff  <= acc_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_acc   = acc_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== rtl/tsl_mul_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsl_mul_chain #(
   parameter int LANES = 1,
   parameter int WA = 32,
   parameter int WB = 32,
   parameter int WS = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       in_valid,
   input  wire logic [LANES*WA-1:0]        in_a,
   input  wire logic [WB-1:0]              in_b,
   input  wire logic [WS-1:0]              in_side,
   output logic                            out_valid,
   output logic [LANES*(WA+WB)-1:0]        out_p,
   output logic [WS-1:0]                   out_side
);

   localparam int WP = WA + WB;

   logic                  v_w    [0:WB];
   logic [LANES*WA-1:0]   a_w    [0:WB-1];
   logic [WB-1:0]         b_w    [0:WB-1];
   logic [LANES*WP-1:0]   acc_w  [0:WB];
   logic [WS-1:0]         side_w [0:WB];

   assign v_w[0]    = in_valid;
   assign a_w[0]    = in_a;
   assign b_w[0]    = in_b;
   assign acc_w[0]  = '0;
   assign side_w[0] = in_side;

   for (genvar i = 0; i < WB; i++) begin : g_cell
      if (i < WB - 1) begin : g_mid
         tsl_mul_cell #(
            .LANES(LANES), .WA(WA), .WB(WB), .WP(WP), .WS(WS), .IDX(i)
         ) u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .in_valid(v_w[i]), .in_a(a_w[i]), .in_b(b_w[i]),
            .in_acc(acc_w[i]), .in_side(side_w[i]),
            .out_valid(v_w[i+1]), .out_a(a_w[i+1]), .out_b(b_w[i+1]),
            .out_acc(acc_w[i+1]), .out_side(side_w[i+1])
         );
      end else begin : g_last
         tsl_mul_cell #(
            .LANES(LANES), .WA(WA), .WB(WB), .WP(WP), .WS(WS), .IDX(i)
         ) u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .in_valid(v_w[i]), .in_a(a_w[i]), .in_b(b_w[i]),
            .in_acc(acc_w[i]), .in_side(side_w[i]),
            .out_valid(v_w[i+1]), .out_a(), .out_b(),
            .out_acc(acc_w[i+1]), .out_side(side_w[i+1])
         );
      end
   end

   assign out_valid = v_w[WB];
   assign out_p     = acc_w[WB];
   assign out_side  = side_w[WB];

endmodule

`default_nettype wire

// ===== rtl/tsl_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsl_div_cell #(
   parameter int WR = 64,
   parameter int WD = 32,
   parameter int WQ = 34,
   parameter int SH = 0,
   parameter int QBIT = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire logic [WR-1:0]   in_rem,
   input  wire logic [WD-1:0]   in_div,
   input  wire logic [WQ-1:0]   in_quo,
   input  wire logic            in_neg,
   output logic                 out_valid,
   output logic [WR-1:0]        out_rem,
   output logic [WD-1:0]        out_div,
   output logic [WQ-1:0]        out_quo,
   output logic                 out_neg
);

   logic            valid_ff;
   logic [WR-1:0]   rem_ff;
   logic [WR-1:0]   rem_in;
   logic [WD-1:0]   div_ff;
   logic [WQ-1:0]   quo_ff;
   logic [WQ-1:0]   quo_in;
   logic            neg_ff;
   logic [WR-1:0]   trial;
   logic            fits;

   always_comb begin
      trial  = WR'(in_div) << SH;
      fits   = (in_rem >= trial);
      rem_in = fits ? (in_rem - trial) : in_rem;
      quo_in = in_quo | (WQ'(fits) << QBIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         div_ff <= in_div;
         quo_ff <= quo_in;
         neg_ff <= in_neg;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quo   = quo_ff;
   assign out_neg   = neg_ff;

endmodule

`default_nettype wire

// ===== verif/tb_tanh_soft_limiter.sv =====
`timescale 1ns / 1ps

module tb_tanh_soft_limiter;
   import tsl_pkg::*;

   localparam int FRAC = 24;
   localparam int OBITS = 32;
   localparam int NUM_RANDOM = 1100;
   localparam int PAUSE_AT = 300;
   localparam int QUIET_LO = 500;
   localparam int QUIET_HI = 700;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      sample_type value;
      logic       clip;
   } limited_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   sample_type req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   sample_type rsp_tdata;
   logic       rsp_tuser;

   sample_type  samples_pending[$];
   limited_type limited_expected[$];
   int          sent_count;
   int          accepted_count;
   int          returned_count;
   int          mismatch_count;

   tanh_soft_limiter #(.FRAC_BITS(FRAC), .OUT_BITS(OBITS)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // exact pade 7/6 quotient, truncated toward zero, saturated to OBITS
   function automatic limited_type pade_limit(sample_type x);
      bit [319:0]  mag;
      bit [319:0]  sq;
      bit [319:0]  num_poly;
      bit [319:0]  den_poly;
      bit [319:0]  n;
      bit [319:0]  d;
      bit [319:0]  quot;
      bit [319:0]  half;
      bit          neg;
      limited_type r;
      neg = x[SAMPLE_BITS-1];
      mag = neg ? 320'(sample_type'(32'd0 - x)) : 320'(x);
      sq = mag * mag;
      num_poly = sq * sq * sq + 320'(NUM_C2) * sq * sq * (320'd1 << (2 * FRAC))
               + 320'(NUM_C1) * sq * (320'd1 << (4 * FRAC))
               + 320'(NUM_C0) * (320'd1 << (6 * FRAC));
      den_poly = 320'd28 * sq * sq * sq + 320'(DEN_C2) * sq * sq * (320'd1 << (2 * FRAC))
               + 320'(DEN_C1) * sq * (320'd1 << (4 * FRAC))
               + 320'(DEN_C0) * (320'd1 << (6 * FRAC));
      n = (mag * num_poly) << (OBITS - 1);
      d = den_poly << FRAC;
      quot = n / d;
      half = 320'd1 << (OBITS - 1);
      r.clip = neg ? (quot > half) : (quot >= half);
      if (r.clip) quot = neg ? half : half - 1;
      quot = neg ? (320'd0 - quot) : quot;
      r.value = sample_type'(quot);
      if (OBITS < SAMPLE_BITS)
         r.value = sample_type'($signed(r.value << (SAMPLE_BITS - OBITS)) >>>
                                (SAMPLE_BITS - OBITS));
      return r;
   endfunction

   function automatic sample_type random_sample();
      int sel;
      sel = $urandom_range(9);
      if (sel < 3) return sample_type'($urandom());
      if (sel < 7) return sample_type'($signed($urandom_range(32'h0800_0000)) *
                                       ($urandom_range(1) ? 1 : -1));
      // near the clipping knee around 4.9
      return sample_type'($signed(32'h04E0_0000 + $urandom_range(32'h0040_0000)) *
                          ($urandom_range(1) ? 1 : -1));
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      samples_pending.push_back(32'h0000_0000);
      samples_pending.push_back(32'h0000_0001);
      samples_pending.push_back(32'hFFFF_FFFF);
      samples_pending.push_back(32'h7FFF_FFFF);
      samples_pending.push_back(32'h8000_0000);
      samples_pending.push_back(32'h8000_0001);
      samples_pending.push_back(32'h0100_0000);
      samples_pending.push_back(32'hFF00_0000);
      samples_pending.push_back(32'h0080_0000);
      samples_pending.push_back(32'h0200_0000);
      samples_pending.push_back(32'h0400_0000);
      samples_pending.push_back(32'h04E6_6666);
      samples_pending.push_back(32'hFB19_999A);
      samples_pending.push_back(32'h0500_0000);
      samples_pending.push_back(32'hFB00_0000);
      samples_pending.push_back(32'h04F0_0000);
      samples_pending.push_back(32'hFB10_0000);
      samples_pending.push_back(32'h0800_0000);
      samples_pending.push_back(32'hF800_0000);
      samples_pending.push_back(32'h5555_5555);
      samples_pending.push_back(32'hAAAA_AAAA);
      for (int i = 0; i < NUM_RANDOM; i++) samples_pending.push_back(random_sample());
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   wire quiet = (sent_count >= QUIET_LO) && (sent_count < QUIET_HI);

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         sent_count <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (samples_pending.size() > 0 &&
             !(sent_count == PAUSE_AT && accepted_count != returned_count) &&
             (quiet || $urandom_range(99) >= 33)) begin
            req_tvalid <= 1'b1;
            req_tdata <= samples_pending.pop_front();
            sent_count <= sent_count + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      limited_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         accepted_count <= 0;
         returned_count <= 0;
         mismatch_count <= 0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 33);
         if (req_tvalid && req_tready) begin
            limited_expected.push_back(pade_limit(req_tdata));
            accepted_count <= accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            returned_count <= returned_count + 1;
            if (limited_expected.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected rsp transaction: data %h clipped %b",
                           rsp_tdata, rsp_tuser);
            end else begin
               want = limited_expected.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser !== want.clip) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: expected %h/%b actual %h/%b",
                              want.value, want.clip, rsp_tdata, rsp_tuser);
               end
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (samples_pending.size() == 0 && !req_tvalid);
      wait (accepted_count == returned_count);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && limited_expected.size() == 0) begin
         $display("tanh_soft_limiter verification clean");
      end else begin
         $display("tanh_soft_limiter verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tanh_soft_limiter verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tsl_pkg.sv
rtl/tsl_mul_cell.sv
rtl/tsl_mul_chain.sv
rtl/tsl_div_cell.sv
rtl/tanh_soft_limiter.sv
verif/tb_tanh_soft_limiter.sv
